/* hw/rtl/gpt_pkg.sv */
// ----------------------------------------------------------------------------
// gpt_pkg: shared definitions for the grid path tracer
// Field widths, function codes, configuration register indexes and the
// sequencer state type used by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package gpt_pkg;

    localparam int FUNC_W = 2;
    localparam int ROW_W  = 7;
    localparam int COL_W  = 7;
    localparam int LEN_W  = 13;
    localparam int CFG_W  = 7;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CFG_W-1:0]  t_cfg;

    // Function codes of an input word.
    localparam t_func FUNC_WRITE = 2'd0;
    localparam t_func FUNC_START = 2'd1;
    localparam t_func FUNC_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam t_cfg GRID_RST = 7'd64;
    localparam t_len LEN_MAX  = 13'd8191;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_PROBE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage

/* hw/rtl/gpt_in_if.sv */
// ----------------------------------------------------------------------------
// gpt_in_if: input channel of the grid path tracer
// Valid/ready channel carrying one command word: function, row, column and
// the track bit for cell writes.
// ----------------------------------------------------------------------------
interface gpt_in_if import gpt_pkg::*; ();

    logic  valid;
    logic  ready;
    t_func func;
    t_row  row;
    t_col  col;
    logic  is_track;

    modport source (output valid, output func, output row, output col,
                    output is_track, input ready);
    modport sink   (input valid, input func, input row, input col,
                    input is_track, output ready);

endinterface

/* hw/rtl/gpt_out_if.sv */
// ----------------------------------------------------------------------------
// gpt_out_if: result channel of the grid path tracer
// Valid/ready channel carrying the position, path length and done flag.
// ----------------------------------------------------------------------------
interface gpt_out_if import gpt_pkg::*; ();

    logic valid;
    logic ready;
    t_row pos_row;
    t_col pos_col;
    t_len path_length;
    logic done_res;

    modport source (output valid, output pos_row, output pos_col,
                    output path_length, output done_res, input ready);
    modport sink   (input valid, input pos_row, input pos_col,
                    input path_length, input done_res, output ready);

endinterface

/* hw/rtl/gpt_ram.sv */
// ----------------------------------------------------------------------------
// gpt_ram: generic single-port synchronous RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module gpt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/grid_path_tracer.sv */
// ----------------------------------------------------------------------------
// grid_path_tracer: four-neighbour path follower over a bit map of cells
// Holds one track bit per cell in a single-port RAM and walks a one-cell-wide
// path through it, at most one move per step command.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as words on i_in (valid/ready); results leave as words on
// o_out (valid/ready). A write command stores one cell bit and gives no
// result. A start command places the current position and returns it with a
// path length of one through the output register. A step command reads the
// neighbours in the order row+1, col+1, row-1, col-1, one RAM read per cycle,
// with the check of one read overlapped with the issue of the next. Its result
// leaves through the output register; when it leaves is set by the single RAM
// port and the number of neighbours probed before a track cell turns up.
// The next command is taken on the cycle after the result is registered.
// After reset the block sweeps the RAM to zero, one cell per cycle, through all
// MAX_ROWS * MAX_COLS cells (4096 at the default size); i_in.ready stays low
// meanwhile, while configuration writes are taken as ever. The result sits in
// an output register; if the receiver stalls while another result is ready,
// the sequencer holds that result and takes no new command until it drains.
// ----------------------------------------------------------------------------
module grid_path_tracer import gpt_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gpt_in_if.sink           i_in,
    gpt_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 8;

    localparam logic [8:0]    MAX_R9    = 9'(MAX_ROWS);
    localparam logic [8:0]    MAX_C9    = 9'(MAX_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Linear RAM address of a one-based cell, rows laid out one after another.
    function automatic logic [AW-1:0] cell_addr(input t_row r, input t_col c);
        logic [PW-1:0] prod;
        prod = PW'(r - 7'd1) * PW'(MAX_COLS);
        return AW'(prod) + AW'(c - 7'd1);
    endfunction

    // True when the cell has a place in the RAM at all.
    function automatic logic in_store(input t_row r, input t_col c);
        return (r != '0) && ({2'b00, r} <= MAX_R9) &&
               (c != '0) && ({2'b00, c} <= MAX_C9);
    endfunction

    // Registers.
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    t_cfg          r_grid_rows, n_grid_rows;
    t_cfg          r_grid_cols, n_grid_cols;
    t_row          r_cur_row, n_cur_row;
    t_col          r_cur_col, n_cur_col;
    t_len          r_visited, n_visited;
    logic          r_done, n_done;
    logic [2:0]    r_k, n_k;
    logic          r_pend_vld, n_pend_vld;
    logic          r_pend_in, n_pend_in;
    t_row          r_pend_row, n_pend_row;
    t_col          r_pend_col, n_pend_col;
    logic          r_ov, n_ov;
    t_row          r_out_row;
    t_col          r_out_col;
    t_len          r_out_len;
    logic          r_out_done;

    // RAM port.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [0:0]    mem_wdata;
    logic [0:0]    mem_rdata;

    // Datapath signals.
    logic [8:0]    rows9, cols9, eff_rows, eff_cols;
    logic [1:0]    k_sel;
    logic [7:0]    nb_r, nb_c;
    logic          nb_in;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] cur_addr;
    logic          hit;
    logic          in_acc;
    logic          out_free;
    logic          out_load;
    logic          fin;
    logic          fin_done;

    gpt_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Grid size in use, capped at the size of the store.
    assign rows9    = {2'b00, r_grid_rows};
    assign cols9    = {2'b00, r_grid_cols};
    assign eff_rows = (rows9 > MAX_R9) ? MAX_R9 : rows9;
    assign eff_cols = (cols9 > MAX_C9) ? MAX_C9 : cols9;

    // Neighbour under probe. A row or column of zero minus one wraps to 255,
    // which always lies beyond the grid, so no separate test is needed.
    assign k_sel = (r_state == S_PROBE) ? r_k[1:0] : 2'd0;

    always_comb begin
        nb_r = {1'b0, r_cur_row};
        nb_c = {1'b0, r_cur_col};
        case (k_sel)
            2'd0:    nb_r = {1'b0, r_cur_row} + 8'd1;
            2'd1:    nb_c = {1'b0, r_cur_col} + 8'd1;
            2'd2:    nb_r = {1'b0, r_cur_row} - 8'd1;
            default: nb_c = {1'b0, r_cur_col} - 8'd1;
        endcase
    end

    assign nb_in   = (nb_r != '0) && ({1'b0, nb_r} <= eff_rows) &&
                     (nb_c != '0) && ({1'b0, nb_c} <= eff_cols);
    assign nb_addr = nb_in ? cell_addr(nb_r[ROW_W-1:0], nb_c[COL_W-1:0]) : '0;
    assign cur_addr = cell_addr(r_cur_row, r_cur_col);

    // The read issued last cycle found a track cell inside the grid.
    assign hit = r_pend_vld && r_pend_in && mem_rdata[0];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_visited   = r_visited;
        n_done      = r_done;
        n_k         = r_k;
        n_pend_vld  = 1'b0;
        n_pend_in   = r_pend_in;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        mem_we      = 1'b0;
        mem_addr    = nb_addr;
        mem_wdata   = 1'b0;
        fin         = 1'b0;
        fin_done    = 1'b0;
        out_load    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.func)
                        FUNC_WRITE: begin
                            mem_we    = in_store(i_in.row, i_in.col);
                            mem_addr  = cell_addr(i_in.row, i_in.col);
                            mem_wdata = i_in.is_track;
                        end
                        FUNC_START: begin
                            n_cur_row = i_in.row;
                            n_cur_col = i_in.col;
                            n_visited = t_len'(1);
                            fin       = 1'b1;
                        end
                        FUNC_STEP: begin
                            // The first neighbour is read right away.
                            n_pend_vld = 1'b1;
                            n_pend_in  = nb_in;
                            n_pend_row = nb_r[ROW_W-1:0];
                            n_pend_col = nb_c[COL_W-1:0];
                            n_k        = 3'd1;
                            n_state    = S_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE: begin
                if (hit) begin
                    // Move: the port clears the cell being left instead of
                    // reading another neighbour.
                    mem_we    = in_store(r_cur_row, r_cur_col);
                    mem_addr  = cur_addr;
                    n_cur_row = r_pend_row;
                    n_cur_col = r_pend_col;
                    if (r_visited != LEN_MAX) begin
                        n_visited = r_visited + 1'b1;
                    end
                    fin = 1'b1;
                end else if (r_k != 3'd4) begin
                    n_pend_vld = 1'b1;
                    n_pend_in  = nb_in;
                    n_pend_row = nb_r[ROW_W-1:0];
                    n_pend_col = nb_c[COL_W-1:0];
                    n_k        = r_k + 3'd1;
                end else begin
                    fin      = 1'b1;
                    fin_done = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished command goes straight to the output register when it is
        // free, and otherwise waits in S_EMIT.
        if (fin) begin
            n_done = fin_done;
            if (out_free) begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_state = S_EMIT;
            end
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_comb begin
        n_grid_rows = r_grid_rows;
        n_grid_cols = r_grid_cols;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: n_grid_rows = i_cfg_data;
                CFG_COLS: n_grid_cols = i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_grid_rows <= GRID_RST;
            r_grid_cols <= GRID_RST;
            r_cur_row   <= t_row'(1);
            r_cur_col   <= t_col'(1);
            r_visited   <= t_len'(1);
            r_done      <= 1'b0;
            r_k         <= '0;
            r_pend_vld  <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_grid_rows <= n_grid_rows;
            r_grid_cols <= n_grid_cols;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_visited   <= n_visited;
            r_done      <= n_done;
            r_k         <= n_k;
            r_pend_vld  <= n_pend_vld;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_in  <= n_pend_in;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        if (out_load) begin
            r_out_row  <= n_cur_row;
            r_out_col  <= n_cur_col;
            r_out_len  <= n_visited;
            r_out_done <= n_done;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.pos_row     = r_out_row;
    assign o_out.pos_col     = r_out_col;
    assign o_out.path_length = r_out_len;
    assign o_out.done_res    = r_out_done;

    // A waiting result is never overwritten before the receiver takes it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |-> !out_load)
        else $error("result register loaded while a result is still waiting");

    // During a trace the only RAM write is the clear of the cell being left.
    a_probe_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && mem_we) |-> (mem_addr == cur_addr && hit))
        else $error("unexpected RAM write during neighbour probe");

    // A read is only checked while the sequencer is probing.
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_PROBE))
        else $error("pending neighbour read outside of probe");

    // The path length never falls to zero.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visited != '0)
        else $error("path length reached zero");

    // The probe index never passes the last neighbour.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_k != 3'd0 && r_k <= 3'd4))
        else $error("neighbour index out of range");

endmodule
